@@ rtl/gpm_pkg.sv @@
// gpm_pkg: shared constants, types and codes of the glob pattern matcher
// used by gpm_ctrl, gpm_datapath and glob_pattern_nfa_matcher; no dependencies
package gpm_pkg;

    localparam int MAX_PATTERN_CHARS = 32;
    localparam int NUM_POS           = MAX_PATTERN_CHARS + 1;
    localparam int POS_W             = $clog2(NUM_POS);
    localparam int PAT_IDX_W         = $clog2(MAX_PATTERN_CHARS);
    localparam int LEN_W             = 6;

    localparam int CHAR_W            = 8;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 3;
    localparam int BYTES_PER_REG     = CFG_DATA_W / CHAR_W;
    localparam int NUM_CHAR_REGS     = MAX_PATTERN_CHARS / BYTES_PER_REG;

    // closure unit walks this many positions per cycle
    localparam int CHUNK_POS         = 4;
    localparam int CHUNK_SHIFT       = $clog2(CHUNK_POS);
    localparam int NUM_CHUNKS        = MAX_PATTERN_CHARS / CHUNK_POS;
    localparam int CHUNK_IDX_W       = $clog2(NUM_CHUNKS);
    localparam int CNT_W             = CHUNK_IDX_W + 1;

    localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_QMARK = 8'h3F;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHARS_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARS_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARS_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARS_3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH  = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_CLOSE_PRE = 5'b00010,
        ST_ADVANCE   = 5'b00100,
        ST_CLOSE_END = 5'b01000,
        ST_EMIT      = 5'b10000
    } state_t;

    typedef struct packed {
        logic load;
        logic close_step;
        logic advance;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic in_consume;
        logic in_end;
        logic item_end;
        logic close_done;
        logic out_free;
    } status_t;

endpackage

@@ rtl/glob_pattern_nfa_matcher.sv @@
// per text byte: star closure over L = pattern length in use, then the byte advance, then s_tready again;
// the star closure unit covers 4 positions per cycle, then one byte step over all positions
// final item: one more closure pass, then the result on m_tvalid, one result per text
// pending result sits in an output register while the next text is taken
// reset: pattern bytes cleared, pattern length 1, only position zero active
// glob_pattern_nfa_matcher: top level, joins gpm_ctrl and gpm_datapath; depends on gpm_pkg
module glob_pattern_nfa_matcher (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gpm_pkg::CHAR_W-1:0]          s_tdata,   // text_char
    input  logic [0:0]                          s_tuser,   // text_empty
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gpm_pkg::CHAR_W-1:0]          m_tdata,   // matched, zero fill
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gpm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gpm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    gpm_pkg::cmd_t    cmd;
    gpm_pkg::status_t status;

    assign cfg_ready = 1'b1;

    gpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gpm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ rtl/gpm_ctrl.sv @@
// gpm_ctrl: sequencing state machine of the glob pattern matcher
// depends on gpm_pkg; drives gpm_datapath through gpm_pkg::cmd_t
module gpm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  gpm_pkg::status_t status,
    output gpm_pkg::cmd_t    cmd
);

    gpm_pkg::state_t state_reg;
    gpm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gpm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            gpm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (status.in_consume)
                    begin
                        state_next = gpm_pkg::ST_CLOSE_PRE;
                    end
                    else if (status.in_end)
                    begin
                        state_next = gpm_pkg::ST_CLOSE_END;
                    end
                end
            end
            gpm_pkg::ST_CLOSE_PRE:
            begin
                if (status.close_done)
                begin
                    state_next = gpm_pkg::ST_ADVANCE;
                end
                else
                begin
                    cmd.close_step = 1'b1;
                end
            end
            gpm_pkg::ST_ADVANCE:
            begin
                cmd.advance = 1'b1;
                state_next  = status.item_end ? gpm_pkg::ST_CLOSE_END : gpm_pkg::ST_IDLE;
            end
            gpm_pkg::ST_CLOSE_END:
            begin
                if (status.close_done)
                begin
                    state_next = gpm_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.close_step = 1'b1;
                end
            end
            gpm_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = gpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gpm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/gpm_datapath.sv @@
// gpm_datapath: pattern registers, active position vector, star closure unit,
// byte advance logic and result register; depends on gpm_pkg
module gpm_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [gpm_pkg::CHAR_W-1:0]          s_tdata,
    input  logic [0:0]                          s_tuser,
    input  logic                                s_tlast,
    input  logic                                cfg_valid,
    input  logic [gpm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gpm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [gpm_pkg::CHAR_W-1:0]          m_tdata,
    input  gpm_pkg::cmd_t                       cmd,
    output gpm_pkg::status_t                    status
);

    logic [gpm_pkg::CFG_DATA_W-1:0] chars_reg [gpm_pkg::NUM_CHAR_REGS];
    logic [gpm_pkg::LEN_W-1:0]      length_reg;
    logic [gpm_pkg::NUM_POS-1:0]    act_reg;
    logic [gpm_pkg::NUM_POS-1:0]    act_next;
    logic [gpm_pkg::CHAR_W-1:0]     char_reg;
    logic                           end_reg;
    logic [gpm_pkg::CNT_W-1:0]      cnt_reg;
    logic [gpm_pkg::CNT_W-1:0]      cnt_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           matched_reg;
    logic                           matched_next;

    logic                           len_valid;
    logic [gpm_pkg::LEN_W-1:0]      len_eff;
    logic [gpm_pkg::CHAR_W-1:0]     pbyte [gpm_pkg::MAX_PATTERN_CHARS];
    logic [gpm_pkg::MAX_PATTERN_CHARS-1:0] in_range;
    logic [gpm_pkg::MAX_PATTERN_CHARS+1:0] star_raw;
    logic [gpm_pkg::MAX_PATTERN_CHARS+1:0] slash_raw;
    logic [gpm_pkg::MAX_PATTERN_CHARS-1:0] star_pos;
    logic [gpm_pkg::MAX_PATTERN_CHARS-1:0] dstar_pos;
    logic [gpm_pkg::MAX_PATTERN_CHARS-1:0] dslash_pos;
    logic [gpm_pkg::MAX_PATTERN_CHARS-1:0] qmark_pos;
    logic [gpm_pkg::NUM_POS-1:0]    closed;
    logic [gpm_pkg::NUM_POS-1:0]    advanced;
    logic                           close_done;
    logic                           out_free;
    logic                           matched_now;

    assign len_valid = length_reg <= gpm_pkg::LEN_W'(gpm_pkg::MAX_PATTERN_CHARS);
    assign len_eff   = len_valid ? length_reg : '0;

    // per-position pattern decode
    always_comb
    begin
        star_raw  = '0;
        slash_raw = '0;
        for (int i = 0; i < gpm_pkg::MAX_PATTERN_CHARS; i++)
        begin
            pbyte[i] = chars_reg[i / gpm_pkg::BYTES_PER_REG]
                                [(i % gpm_pkg::BYTES_PER_REG) * gpm_pkg::CHAR_W +: gpm_pkg::CHAR_W];
            in_range[i]  = gpm_pkg::LEN_W'(i) < len_eff;
            star_raw[i]  = in_range[i] && (pbyte[i] == gpm_pkg::CHAR_STAR);
            slash_raw[i] = in_range[i] && (pbyte[i] == gpm_pkg::CHAR_SLASH);
            qmark_pos[i] = in_range[i] && (pbyte[i] == gpm_pkg::CHAR_QMARK);
        end
        for (int i = 0; i < gpm_pkg::MAX_PATTERN_CHARS; i++)
        begin
            star_pos[i]   = star_raw[i];
            dstar_pos[i]  = star_raw[i] && star_raw[i + 1];
            dslash_pos[i] = slash_raw[i + 2];
        end
    end

    // star closure over one chunk of positions, in ascending order
    always_comb
    begin
        logic [gpm_pkg::NUM_POS+2:0]     tmp;
        logic [gpm_pkg::PAT_IDX_W-1:0]   base;
        logic [gpm_pkg::PAT_IDX_W-1:0]   pos;
        logic [gpm_pkg::POS_W-1:0]       pos_w;
        tmp  = {3'b000, act_reg};
        base = {cnt_reg[gpm_pkg::CHUNK_IDX_W-1:0], gpm_pkg::CHUNK_SHIFT'(0)};
        for (int k = 0; k < gpm_pkg::CHUNK_POS; k++)
        begin
            pos   = base + gpm_pkg::PAT_IDX_W'(k);
            pos_w = {1'b0, pos};
            if (tmp[pos_w] && star_pos[pos])
            begin
                if (dstar_pos[pos])
                begin
                    tmp[pos_w + gpm_pkg::POS_W'(2)] = 1'b1;
                    if (dslash_pos[pos])
                    begin
                        tmp[pos_w + gpm_pkg::POS_W'(3)] = 1'b1;
                    end
                end
                else
                begin
                    tmp[pos_w + gpm_pkg::POS_W'(1)] = 1'b1;
                end
            end
        end
        closed = tmp[gpm_pkg::NUM_POS-1:0];
    end

    // byte step, all positions in parallel
    always_comb
    begin
        logic c_slash;
        c_slash  = char_reg == gpm_pkg::CHAR_SLASH;
        advanced = '0;
        for (int i = 0; i < gpm_pkg::MAX_PATTERN_CHARS; i++)
        begin
            if (act_reg[i] && in_range[i])
            begin
                if (star_pos[i])
                begin
                    if (dstar_pos[i] || !c_slash)
                    begin
                        advanced[i] = 1'b1;
                    end
                end
                else if ((qmark_pos[i] && !c_slash) || (pbyte[i] == char_reg))
                begin
                    advanced[i + 1] = 1'b1;
                end
            end
        end
    end

    assign close_done  = {cnt_reg, gpm_pkg::CHUNK_SHIFT'(0)} >= len_eff;
    assign out_free    = !out_valid_reg || m_tready;
    assign matched_now = len_valid && act_reg[len_eff];

    always_comb
    begin
        act_next       = act_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        matched_next   = matched_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish)
        begin
            act_next       = gpm_pkg::NUM_POS'(1);
            out_valid_next = 1'b1;
            matched_next   = matched_now;
        end
        else if (cmd.advance)
        begin
            act_next = advanced;
        end
        else if (cmd.close_step)
        begin
            act_next = closed;
        end
        if (cmd.load || cmd.advance)
        begin
            cnt_next = '0;
        end
        else if (cmd.close_step)
        begin
            cnt_next = cnt_reg + gpm_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < gpm_pkg::NUM_CHAR_REGS; r++)
            begin
                chars_reg[r] <= '0;
            end
            length_reg    <= gpm_pkg::LEN_W'(1);
            act_reg       <= gpm_pkg::NUM_POS'(1);
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            end_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    gpm_pkg::CFG_CHARS_0: chars_reg[0] <= cfg_data;
                    gpm_pkg::CFG_CHARS_1: chars_reg[1] <= cfg_data;
                    gpm_pkg::CFG_CHARS_2: chars_reg[2] <= cfg_data;
                    gpm_pkg::CFG_CHARS_3: chars_reg[3] <= cfg_data;
                    gpm_pkg::CFG_LENGTH:  length_reg   <= cfg_data[gpm_pkg::LEN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            act_reg       <= act_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cmd.load)
            begin
                end_reg <= s_tuser[0] || s_tlast;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg <= s_tdata;
        end
        matched_reg <= matched_next;
    end

    assign status.in_consume = !s_tuser[0] && len_valid;
    assign status.in_end     = s_tuser[0] || s_tlast;
    assign status.item_end   = end_reg;
    assign status.close_done = close_done;
    assign status.out_free   = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(gpm_pkg::CHAR_W-1){1'b0}}, matched_reg};

`ifndef ASSERT_OFF
    a_step_not_past_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close_step |-> !close_done)
        else $error("closure step issued past pattern length");

    a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || m_tready))
        else $error("result overwrites a pending transfer");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= gpm_pkg::CNT_W'(gpm_pkg::NUM_CHUNKS))
        else $error("chunk counter out of range");

    a_finish_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (act_reg == gpm_pkg::NUM_POS'(1)) && out_valid_reg)
        else $error("state not restarted after result");
`endif

endmodule
